// File: rtl/lsm_pkg.sv
// Shared types and constants for the latency statistics monitor.
`default_nettype none

package lsm_pkg;

    localparam int unsigned CHANNELS_DEFAULT = 8;

    localparam logic [31:0] PERIOD_RESET = 32'd1000;
    localparam logic        LOOP_RESET   = 1'b1;

    // Operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Register indexes on the config port
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_LOOP   = 1'b1;

    localparam logic [63:0] MIN_RESET = 64'h0000_0000_ffff_ffff;
    localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

    // Divider: one quotient bit per cycle
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] min_v;
        logic [63:0] max_v;
        logic [63:0] total;
    } stats_t;

    localparam stats_t STATS_CLEAR = '{
        count: 32'd0,
        min_v: MIN_RESET,
        max_v: 64'd0,
        total: 64'd0
    };

    typedef struct packed {
        logic rd_en;
        logic stamp_we;
        logic stats_we;
    } store_ctl_t;

endpackage

`default_nettype wire

// File: rtl/lsm_store.sv
// Per-channel state memories: start stamps and statistics, with per-entry valid bits.
`default_nettype none

module lsm_store
    import lsm_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEFAULT,
    parameter int unsigned CHW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire store_ctl_t       ctl,
    input  wire logic [CHW-1:0]   addr,
    input  wire logic [63:0]      stamp_wdata,
    input  wire stats_t           stats_wdata,
    output logic [63:0]           stamp_rdata,
    output stats_t                stats_rdata
);

    logic [63:0]         stamp_mem [CHANNELS];
    stats_t              stats_mem [CHANNELS];
    logic [CHANNELS-1:0] stamp_vld_reg;
    logic [CHANNELS-1:0] stats_vld_reg;

    logic [63:0] stamp_q_reg;
    stats_t      stats_q_reg;
    logic        stamp_qv_reg;
    logic        stats_qv_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.stamp_we)
        begin
            stamp_mem[addr] <= stamp_wdata;
        end
        if (ctl.stats_we)
        begin
            stats_mem[addr] <= stats_wdata;
        end
        if (ctl.rd_en)
        begin
            stamp_q_reg <= stamp_mem[addr];
            stats_q_reg <= stats_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_vld_reg <= '0;
            stats_vld_reg <= '0;
            stamp_qv_reg  <= 1'b0;
            stats_qv_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.stamp_we)
            begin
                stamp_vld_reg[addr] <= 1'b1;
            end
            if (ctl.stats_we)
            begin
                stats_vld_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                stamp_qv_reg <= stamp_vld_reg[addr];
                stats_qv_reg <= stats_vld_reg[addr];
            end
        end
    end

    // never-written entries read as their reset values
    assign stamp_rdata = stamp_qv_reg ? stamp_q_reg : 64'd0;
    assign stats_rdata = stats_qv_reg ? stats_q_reg : STATS_CLEAR;

endmodule

`default_nettype wire

// File: rtl/lsm_divider.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none

module lsm_divider
    import lsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          dq_reg, dq_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic [32:0]          trial;
    logic [32:0]          diff;
    logic                 qbit;

    // dq_reg shifts dividend bits out at the top and quotient bits in at the bottom
    assign trial = {rem_reg, dq_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next = cnt_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dq_next  = {dq_reg[62:0], qbit};
            rem_next = qbit ? diff[31:0] : trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = dq_reg;

endmodule

`default_nettype wire

// File: rtl/latency_statistics_monitor_top.sv
// Top level of the latency statistics monitor: control sequencer, config registers, report output.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      operation, channel, timestamp_ns
//  report    out        report_valid / report_stall  report_channel .. empty_flag
//  config    in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
// A start mark is written to the stamp memory on acceptance. An end mark or query
// goes from acceptance to the report register through memory read, elapsed subtract,
// update/writeback, the bit-serial divider for the average (ST_DIVIDE waits to see it
// finish) and ST_FINISH to load the output. A query on an empty channel skips the divider.
// The item port reopens the cycle after the report is loaded.
// Reset clears all channel statistics at once through per-entry valid bits.
// A stalled report holds in its register; the next item is still accepted meanwhile.
`default_nettype none

module latency_statistics_monitor_top
    import lsm_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [2:0]  channel,
    input  wire logic [63:0] timestamp_ns,
    // report channel
    output logic             report_valid,
    input  wire logic        report_stall,
    output logic [2:0]       report_channel,
    output logic             period_done,
    output logic [31:0]      sample_count,
    output logic [63:0]      min_ns,
    output logic [63:0]      max_ns,
    output logic [63:0]      total_ns,
    output logic [63:0]      average_ns,
    output logic             empty_flag,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned XW  = (CHW > 3) ? CHW : 3;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [31:0] period_reg;
    logic        loop_reg;
    logic        cfg_wr;

    // item context
    logic [1:0]  op_reg, op_next;
    logic [2:0]  chan_reg, chan_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [63:0] elapsed_reg, elapsed_next;
    stats_t      rpt_reg, rpt_next;
    logic        done_reg, done_next;

    // report outputs
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_chan_reg;
    logic        out_done_reg;
    stats_t      out_stats_reg;
    logic [63:0] out_avg_reg;
    logic        out_empty_reg;
    logic        out_load;

    logic           accept;
    logic [XW-1:0]  chan_x;
    logic           chan_ok;
    logic [CHW-1:0] addr;

    store_ctl_t  ctl;
    stats_t      stats_rdata;
    stats_t      stats_wdata;
    stats_t      stats_new;
    logic [63:0] stamp_rdata;
    logic        hit_done;

    logic        div_start;
    logic        div_busy;
    logic [63:0] quotient;

    function automatic logic [CHW-1:0] chan_reg_x();
        logic [XW-1:0] cx;
        cx = XW'(chan_reg);
        return cx[CHW-1:0];
    endfunction

    assign accept  = item_valid && !item_stall;
    assign chan_x  = XW'(channel);
    assign chan_ok = (32'(channel) < CHANNELS);
    assign addr    = (state_reg == ST_IDLE) ? chan_x[CHW-1:0] : chan_reg_x();

    // new statistics for an end mark
    always_comb
    begin
        stats_new.count = (stats_rdata.count == COUNT_MAX) ? stats_rdata.count
                                                           : stats_rdata.count + 32'd1;
        stats_new.min_v = (elapsed_reg < stats_rdata.min_v) ? elapsed_reg : stats_rdata.min_v;
        stats_new.max_v = (elapsed_reg > stats_rdata.max_v) ? elapsed_reg : stats_rdata.max_v;
        stats_new.total = stats_rdata.total + elapsed_reg;
    end

    assign hit_done    = (stats_new.count >= period_reg);
    assign stats_wdata = (hit_done && loop_reg) ? STATS_CLEAR : stats_new;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        chan_next    = chan_reg;
        stamp_next   = stamp_reg;
        elapsed_next = elapsed_reg;
        rpt_next     = rpt_reg;
        done_next    = done_reg;
        ctl          = '0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        out_valid_next = out_valid_reg && report_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                op_next    = operation;
                chan_next  = channel;
                stamp_next = timestamp_ns;
                if (accept && chan_ok)
                begin
                    if (operation == OP_START)
                    begin
                        ctl.stamp_we = 1'b1;
                    end
                    else if (operation == OP_END || operation == OP_QUERY)
                    begin
                        ctl.rd_en  = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                elapsed_next = stamp_reg - stamp_rdata;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (op_reg == OP_END)
                begin
                    ctl.stats_we = 1'b1;
                    rpt_next     = stats_new;
                    done_next    = hit_done;
                    div_start    = 1'b1;
                end
                else
                begin
                    rpt_next  = stats_rdata;
                    done_next = 1'b0;
                    div_start = (stats_rdata.count != 32'd0);
                end
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !report_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            period_reg    <= PERIOD_RESET;
            loop_reg      <= LOOP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_PERIOD: period_reg <= pwdata;
                    REG_LOOP:   loop_reg   <= pwdata[0];
                    default:    period_reg <= period_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        chan_reg    <= chan_next;
        stamp_reg   <= stamp_next;
        elapsed_reg <= elapsed_next;
        rpt_reg     <= rpt_next;
        done_reg    <= done_next;
        if (out_load)
        begin
            out_chan_reg  <= chan_reg;
            out_done_reg  <= done_reg;
            out_stats_reg <= rpt_reg;
            out_empty_reg <= (rpt_reg.count == 32'd0);
            out_avg_reg   <= (rpt_reg.count == 32'd0) ? 64'd0 : quotient;
        end
    end

    lsm_store #(
        .CHANNELS (CHANNELS),
        .CHW      (CHW)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .addr        (addr),
        .stamp_wdata (stamp_next),
        .stats_wdata (stats_wdata),
        .stamp_rdata (stamp_rdata),
        .stats_rdata (stats_rdata)
    );

    lsm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rpt_next.total),
        .divisor  (rpt_next.count),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_PERIOD: prdata = period_reg;
            REG_LOOP:   prdata = {31'd0, loop_reg};
            default:    prdata = '0;
        endcase
    end

    assign item_stall     = (state_reg != ST_IDLE);
    assign report_valid   = out_valid_reg;
    assign report_channel = out_chan_reg;
    assign period_done    = out_done_reg;
    assign sample_count   = out_stats_reg.count;
    assign min_ns         = out_stats_reg.min_v;
    assign max_ns         = out_stats_reg.max_v;
    assign total_ns       = out_stats_reg.total;
    assign average_ns     = out_avg_reg;
    assign empty_flag     = out_empty_reg;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the latency statistics monitor top level.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lsm_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 90;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 60;

    typedef struct packed {
        logic [2:0]  chan;
        logic        done;
        logic [31:0] count;
        logic [63:0] min_v;
        logic [63:0] max_v;
        logic [63:0] total;
        logic [63:0] avg;
        logic        empty;
    } latency_report_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t       kind;
        logic [1:0]      op;
        logic [2:0]      ch;
        logic [63:0]     ts;
        bit              typed;
        latency_report_t want;
        logic            reg_idx;
        logic [31:0]     reg_val;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic [63:0] timestamp_ns;
    logic        report_valid;
    logic        report_stall;
    logic [2:0]  report_channel;
    logic        period_done;
    logic [31:0] sample_count;
    logic [63:0] min_ns;
    logic [63:0] max_ns;
    logic [63:0] total_ns;
    logic [63:0] average_ns;
    logic        empty_flag;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // per-channel latency statistics as the block should hold them
    logic [63:0] mark_ns  [8];
    logic [31:0] samples  [8];
    logic [63:0] shortest [8];
    logic [63:0] longest  [8];
    logic [63:0] sum_ns   [8];
    logic [31:0] cfg_period;
    logic        cfg_loop;

    latency_report_t pending_reports[$];
    stim_row_t       stim_rows[$];

    int  errors;
    int  items_sent;
    int  reports_checked;
    int  periods_seen;
    int  cfg_writes;
    bit  tx_calm;
    bit  rx_calm;
    logic [63:0] wall_ns;

    logic [31:0] phase_period [PHASES] = '{32'd1, 32'd2, 32'd3, 32'hffff_ffff,
                                           32'd0, 32'd4, 32'd1, 32'd5};
    logic        phase_loop   [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    latency_statistics_monitor_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .channel        (channel),
        .timestamp_ns   (timestamp_ns),
        .report_valid   (report_valid),
        .report_stall   (report_stall),
        .report_channel (report_channel),
        .period_done    (period_done),
        .sample_count   (sample_count),
        .min_ns         (min_ns),
        .max_ns         (max_ns),
        .total_ns       (total_ns),
        .average_ns     (average_ns),
        .empty_flag     (empty_flag),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t: report %0d: %s = %h, expected %h", $realtime, reports_checked,
                 field, got, want);
    endtask

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Updates the statistics for one transaction; returns 1 when a report follows.
    function automatic bit predict_report(input logic [1:0] op, input logic [2:0] ch,
                                          input logic [63:0] ts,
                                          output latency_report_t rpt);
        logic [63:0] elapsed;
        logic        wrap;
        rpt  = '0;
        wrap = 1'b0;
        if (op == OP_START)
        begin
            mark_ns[ch] = ts;
            return 1'b0;
        end
        if (op != OP_END && op != OP_QUERY)
            return 1'b0;
        if (op == OP_END)
        begin
            elapsed = ts - mark_ns[ch];
            if (samples[ch] != COUNT_MAX)
                samples[ch]++;
            if (elapsed < shortest[ch])
                shortest[ch] = elapsed;
            if (elapsed > longest[ch])
                longest[ch] = elapsed;
            sum_ns[ch] += elapsed;
            wrap = (samples[ch] >= cfg_period);
        end
        rpt.chan  = ch;
        rpt.done  = wrap;
        rpt.count = samples[ch];
        rpt.min_v = shortest[ch];
        rpt.max_v = longest[ch];
        rpt.total = sum_ns[ch];
        rpt.avg   = (samples[ch] != 0) ? sum_ns[ch] / {32'd0, samples[ch]} : 64'd0;
        rpt.empty = (samples[ch] == 0);
        // loop clear happens after the report is formed; start mark survives
        if (wrap && cfg_loop)
        begin
            samples[ch]  = '0;
            shortest[ch] = MIN_RESET;
            longest[ch]  = '0;
            sum_ns[ch]   = '0;
        end
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] op, input logic [2:0] ch,
                             input logic [63:0] ts, input bit typed = 1'b0,
                             input latency_report_t want = '0);
        int              gap;
        latency_report_t rpt;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   = 1'b1;
        operation    = op;
        channel      = ch;
        timestamp_ns = ts;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        items_sent++;
        if (predict_report(op, ch, ts, rpt))
            pending_reports.push_back(typed ? want : rpt);
        @(negedge clk);
    endtask

    // Block is idle once every report is back and the pipeline has drained.
    task automatic settle_idle();
        item_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] mask;
        mask    = (idx == REG_LOOP) ? 32'h1 : 32'hffff_ffff;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        if (idx == REG_PERIOD)
            cfg_period = value;
        else
            cfg_loop = value[0];
        cfg_writes++;
        // read back
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if ((prdata & mask) !== (value & mask))
            report_mismatch("register readback", 64'(prdata & mask), 64'(value & mask));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic void row_item(input logic [1:0] op, input logic [2:0] ch,
                                     input logic [63:0] ts);
        stim_row_t row;
        row       = '{kind: ROW_ITEM, default: '0};
        row.op    = op;
        row.ch    = ch;
        row.ts    = ts;
        stim_rows.push_back(row);
    endfunction

    function automatic void row_typed(input logic [1:0] op, input logic [2:0] ch,
                                      input logic [63:0] ts, input latency_report_t want);
        stim_row_t row;
        row       = '{kind: ROW_ITEM, default: '0};
        row.op    = op;
        row.ch    = ch;
        row.ts    = ts;
        row.typed = 1'b1;
        row.want  = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void row_cfg(input logic idx, input logic [31:0] value);
        stim_row_t row;
        row         = '{kind: ROW_CFG, default: '0};
        row.reg_idx = idx;
        row.reg_val = value;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [63:0] pick_elapsed();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 64'($urandom_range(0, 2000));
        if (r < 85)
            return 64'($urandom);
        if (r < 95)
            return {$urandom, $urandom};
        // straddle the reset value of the minimum
        return MIN_RESET - 64'd1 + 64'($urandom_range(0, 2));
    endfunction

    task automatic random_burst(input int count);
        int          sent;
        int          r;
        logic [2:0]  ch;
        logic [63:0] elapsed;
        sent = 0;
        while (sent < count)
        begin
            ch = 3'($urandom_range(7));
            r  = $urandom_range(99);
            if (r < 45)
            begin
                wall_ns += 64'($urandom_range(1, 1000));
                send_item(OP_START, ch, wall_ns);
                elapsed = pick_elapsed();
                if ($urandom_range(3) == 0)
                begin
                    send_item(OP_QUERY, 3'($urandom_range(7)), {$urandom, $urandom});
                    sent++;
                end
                send_item(OP_END, ch, wall_ns + elapsed);
                wall_ns += elapsed;
                sent += 2;
            end
            else if (r < 60)
            begin
                wall_ns += 64'($urandom_range(0, 5000));
                send_item(OP_END, ch, wall_ns);
                sent++;
            end
            else if (r < 75)
            begin
                send_item(OP_QUERY, ch, {$urandom, $urandom});
                sent++;
            end
            else if (r < 83)
            begin
                send_item(OP_START, ch, {$urandom, $urandom});
                sent++;
            end
            else if (r < 89)
                send_item(OP_UNUSED, ch, {$urandom, $urandom});
            else
            begin
                send_item(OP_END, ch, {$urandom, $urandom});
                sent++;
            end
        end
    endtask

    initial
    begin
        report_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int n;
            n = pick_gap(rx_calm);
            @(negedge clk);
            report_stall = (n != 0);
            repeat (n) @(negedge clk);
            report_stall = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : report_check
        latency_report_t want;
        if (report_valid === 1'b1 && report_stall === 1'b0)
        begin
            if (pending_reports.size() == 0)
                report_mismatch("report_valid", 64'd1, 64'd0);
            else
            begin
                want = pending_reports.pop_front();
                if (report_channel !== want.chan)
                    report_mismatch("report_channel", 64'(report_channel), 64'(want.chan));
                if (period_done !== want.done)
                    report_mismatch("period_done", 64'(period_done), 64'(want.done));
                if (sample_count !== want.count)
                    report_mismatch("sample_count", 64'(sample_count), 64'(want.count));
                if (min_ns !== want.min_v)
                    report_mismatch("min_ns", min_ns, want.min_v);
                if (max_ns !== want.max_v)
                    report_mismatch("max_ns", max_ns, want.max_v);
                if (total_ns !== want.total)
                    report_mismatch("total_ns", total_ns, want.total);
                if (average_ns !== want.avg)
                    report_mismatch("average_ns", average_ns, want.avg);
                if (empty_flag !== want.empty)
                    report_mismatch("empty_flag", 64'(empty_flag), 64'(want.empty));
                if (period_done === 1'b1)
                    periods_seen++;
                reports_checked++;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        operation    = OP_QUERY;
        channel      = '0;
        timestamp_ns = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        errors       = 0;
        items_sent   = 0;
        reports_checked = 0;
        periods_seen = 0;
        cfg_writes   = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        cfg_period   = PERIOD_RESET;
        cfg_loop     = LOOP_RESET;
        for (int c = 0; c < 8; c++)
        begin
            mark_ns[c]  = '0;
            samples[c]  = '0;
            shortest[c] = MIN_RESET;
            longest[c]  = '0;
            sum_ns[c]   = '0;
        end

        // channels fresh out of reset
        row_typed(OP_QUERY, 3'd0, 64'd0,
                  latency_report_t'{3'd0, 1'b0, 32'd0, MIN_RESET, 64'd0, 64'd0, 64'd0, 1'b1});
        row_typed(OP_QUERY, 3'd7, '1,
                  latency_report_t'{3'd7, 1'b0, 32'd0, MIN_RESET, 64'd0, 64'd0, 64'd0, 1'b1});
        // end mark with no start uses the zero stamp
        row_typed(OP_END, 3'd3, 64'd100,
                  latency_report_t'{3'd3, 1'b0, 32'd1, 64'd100, 64'd100, 64'd100, 64'd100,
                                    1'b0});
        // elapsed wraps around 2^64
        row_item(OP_START, 3'd1, 64'hffff_ffff_ffff_fff0);
        row_typed(OP_END, 3'd1, 64'h10,
                  latency_report_t'{3'd1, 1'b0, 32'd1, 64'h20, 64'h20, 64'h20, 64'h20, 1'b0});
        // largest elapsed leaves the minimum at its reset value
        row_item(OP_START, 3'd2, 64'd0);
        row_typed(OP_END, 3'd2, '1,
                  latency_report_t'{3'd2, 1'b0, 32'd1, MIN_RESET, '1, '1, '1, 1'b0});
        row_item(OP_END, 3'd2, '1);              // total wraps
        row_item(OP_UNUSED, 3'd5, 64'h0123_4567_89ab_cdef);
        row_typed(OP_QUERY, 3'd5, 64'd0,
                  latency_report_t'{3'd5, 1'b0, 32'd0, MIN_RESET, 64'd0, 64'd0, 64'd0, 1'b1});
        row_item(OP_QUERY, 3'd2, 64'd0);
        row_item(OP_START, 3'd4, 64'd1000);
        row_item(OP_END, 3'd4, 64'd1000);        // zero elapsed
        row_item(OP_START, 3'd6, 64'haaaa_aaaa_aaaa_aaaa);
        row_item(OP_END, 3'd6, 64'h5555_5555_5555_5555);
        // loop clear after every sample
        row_cfg(REG_PERIOD, 32'd1);
        row_cfg(REG_LOOP, 32'd1);
        row_item(OP_END, 3'd6, 64'h5555_5555_5555_555a);
        row_typed(OP_QUERY, 3'd6, 64'd0,
                  latency_report_t'{3'd6, 1'b0, 32'd0, MIN_RESET, 64'd0, 64'd0, 64'd0, 1'b1});
        // period zero, no clearing: done on every end mark
        row_cfg(REG_PERIOD, 32'd0);
        row_cfg(REG_LOOP, 32'd0);
        row_item(OP_END, 3'd4, 64'd2000);
        row_item(OP_END, 3'd4, 64'd3500);
        row_item(OP_QUERY, 3'd4, 64'd0);
        row_cfg(REG_PERIOD, 32'hffff_ffff);
        row_cfg(REG_LOOP, 32'd1);
        row_item(OP_END, 3'd0, 64'd7);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                settle_idle();
                write_register(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end
            else
                send_item(stim_rows[i].op, stim_rows[i].ch, stim_rows[i].ts,
                          stim_rows[i].typed, stim_rows[i].want);
        end

        wall_ns = {$urandom, $urandom};
        phase_period[6] = 32'($urandom_range(1, 6));
        for (int p = 0; p < PHASES; p++)
        begin
            settle_idle();
            write_register(REG_PERIOD, phase_period[p]);
            write_register(REG_LOOP, {31'd0, phase_loop[p]});
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 3 == 2);
            random_burst(PHASE_ITEMS);
        end

        settle_idle();
        $display("Sent %0d transactions over %0d register writes; checked %0d reports,",
                 items_sent, cfg_writes, reports_checked);
        $display("%0d of them closing a period.", periods_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
